/* hw/rtl/olmg_pkg.sv */
// ----------------------------------------------------------------------------
// olmg_pkg
// Shared constants and bit-search helpers for the obstacle line gap block.
// ----------------------------------------------------------------------------
package olmg_pkg;

  localparam int LINE_LEN_DEF = 65536;
  localparam int WORD_BITS    = 64;
  localparam int BIT_W        = 6;
  localparam int POS_IN_W     = 16;
  localparam int SIZE_W       = 17;

  function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // bits 0..b set
  function automatic logic [WORD_BITS-1:0] mask_upto(input logic [BIT_W-1:0] b);
    logic [WORD_BITS-1:0] m;
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = (BIT_W'(i) <= b);
    end
    return m;
  endfunction

endpackage

/* hw/rtl/olmg_map_ram.sv */
// ----------------------------------------------------------------------------
// olmg_map_ram
// Obstacle bitmap, 64 positions per word, one write and one read port.
// ----------------------------------------------------------------------------
module olmg_map_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  wa,
  input  logic [olmg_pkg::WORD_BITS-1:0] wd,
  input  logic [AW-1:0]                  ra,
  output logic [olmg_pkg::WORD_BITS-1:0] rd
);
  import olmg_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd <= mem[ra];
  end

endmodule

/* hw/rtl/olmg_tree_ram.sv */
// ----------------------------------------------------------------------------
// olmg_tree_ram
// Gap max tree storage, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module olmg_tree_ram #(
  parameter int DEPTH = 131072,
  parameter int AW    = 17,
  parameter int DW    = 17
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd,
  input  logic [AW-1:0] ra_a,
  input  logic [AW-1:0] ra_b,
  output logic [DW-1:0] rd_a,
  output logic [DW-1:0] rd_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

endmodule

/* hw/rtl/obstacle_line_max_gap_query.sv */
// ----------------------------------------------------------------------------
// obstacle_line_max_gap_query
// Obstacle set on a line with a range-max tree of the gaps ending at each
// obstacle. Place inserts an obstacle; query reports whether a block fits.
// ----------------------------------------------------------------------------
// One request at a time. A place walks the bitmap back to the previous and
// forward to the next obstacle, then updates the tree one level a cycle on
// the tree RAM write/read pair; a query walks back to the previous obstacle
// and then folds the range max over the tree.
// After reset a clearing pass sweeps both memories; no request is taken
// until it ends.
module obstacle_line_max_gap_query #(
  parameter int LINE_LEN = olmg_pkg::LINE_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [olmg_pkg::POS_IN_W-1:0] position,
  input  logic [olmg_pkg::SIZE_W-1:0]   block_size,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          fits
);
  import olmg_pkg::*;

  localparam int MAP_WORDS = (LINE_LEN + WORD_BITS - 1) / WORD_BITS;
  localparam int MWB       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int DW        = $clog2(LINE_LEN + 1);
  localparam int PW        = (DW > SIZE_W) ? DW : SIZE_W;
  localparam int TDEPTH    = 2 * LINE_LEN;
  localparam int TW        = $clog2(TDEPTH);
  localparam int HW        = $clog2(TDEPTH + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CHK, S_PWALK, S_NSTART, S_NWALK,
    S_MWR, S_TLEAF, S_TUP, S_TMAX, S_FIN
  } state_t;

  state_t               state;
  logic                 cmd;
  logic [PW-1:0]        pos;
  logic [PW-1:0]        xq;
  logic [SIZE_W-1:0]    bs;
  logic [MWB-1:0]       w;
  logic [MWB-1:0]       pw;
  logic [BIT_W-1:0]     bitn;
  logic [WORD_BITS-1:0] wbuf;
  logic [PW-1:0]        prev;
  logic [PW-1:0]        nxt;
  logic [TW-1:0]        node;
  logic [DW-1:0]        cur;
  logic                 second;
  logic [HW-1:0]        lo;
  logic [HW-1:0]        hi;
  logic                 pa;
  logic                 pb;
  logic [DW-1:0]        best;
  logic [TW-1:0]        clr;

  logic                 map_we;
  logic [MWB-1:0]       map_wa;
  logic [WORD_BITS-1:0] map_wd;
  logic [MWB-1:0]       map_ra;
  logic [WORD_BITS-1:0] map_rd;
  logic                 tr_we;
  logic [TW-1:0]        tr_wa;
  logic [DW-1:0]        tr_wd;
  logic [TW-1:0]        tr_ra;
  logic [TW-1:0]        tr_rb;
  logic [DW-1:0]        rd_a;
  logic [DW-1:0]        rd_b;

  logic [PW-1:0]        pos_in;
  logic [PW-1:0]        x_in;
  logic [PW-1:0]        look_in;
  logic [WORD_BITS-1:0] bits_p;
  logic                 prv_hit;
  logic [PW-1:0]        prv_val;
  logic [WORD_BITS-1:0] nb;
  logic [DW-1:0]        up_max;
  logic [DW-1:0]        fold_a;
  logic [DW-1:0]        fold_b;
  logic [DW-1:0]        tail;
  logic [DW-1:0]        fin_max;
  logic [TW-1:0]        parent;

  olmg_map_ram #(.DEPTH(MAP_WORDS), .AW(MWB)) u_map (
    .clk(clk), .we(map_we), .wa(map_wa), .wd(map_wd), .ra(map_ra), .rd(map_rd)
  );

  olmg_tree_ram #(.DEPTH(TDEPTH), .AW(TW), .DW(DW)) u_tree (
    .clk(clk), .we(tr_we), .wa(tr_wa), .wd(tr_wd),
    .ra_a(tr_ra), .ra_b(tr_rb), .rd_a(rd_a), .rd_b(rd_b)
  );

  assign in_ready = (state == S_IDLE);

  always_comb begin
    pos_in  = PW'(position);
    x_in    = (pos_in > PW'(LINE_LEN)) ? PW'(LINE_LEN) : pos_in;
    look_in = command ? ((x_in < PW'(LINE_LEN)) ? x_in : PW'(LINE_LEN - 1)) : pos_in;

    bits_p  = (state == S_CHK) ? (map_rd & mask_upto(bitn)) : map_rd;
    prv_hit = (bits_p != '0) || (w == '0);
    prv_val = (bits_p != '0) ? ((PW'(w) << BIT_W) | PW'(top_bit(bits_p))) : '0;
    nb      = wbuf & ~mask_upto(bitn);

    parent  = node >> 1;
    up_max  = (rd_a > cur) ? rd_a : cur;
    fold_a  = (pa && rd_a > best) ? rd_a : best;
    fold_b  = (pb && rd_b > fold_a) ? rd_b : fold_a;
    tail    = DW'(xq - prev);
    fin_max = (tail > best) ? tail : best;

    map_we = 1'b0;
    map_wa = pw;
    map_wd = wbuf | (WORD_BITS'(1) << bitn);
    map_ra = w - MWB'(1);
    tr_we  = 1'b0;
    tr_wa  = node;
    tr_wd  = cur;
    tr_ra  = node ^ TW'(1);
    tr_rb  = TW'(hi - HW'(1));
    unique case (state)
      S_CLR: begin
        map_we = (int'(clr) < MAP_WORDS);
        map_wa = MWB'(clr);
        map_wd = (clr == '0) ? WORD_BITS'(1) : '0;
        tr_we  = 1'b1;
        tr_wa  = clr;
        tr_wd  = '0;
      end
      S_IDLE:   map_ra = MWB'(look_in >> BIT_W);
      S_NSTART: map_ra = pw + MWB'(1);
      S_NWALK:  map_ra = w + MWB'(1);
      S_MWR:    map_we = 1'b1;
      S_TLEAF:  tr_we = 1'b1;
      S_TUP: begin
        tr_we = 1'b1;
        tr_wa = parent;
        tr_wd = up_max;
        tr_ra = parent ^ TW'(1);
      end
      S_TMAX:   tr_ra = TW'(lo);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      out_valid <= 1'b0;
      second    <= 1'b0;
      pa        <= 1'b0;
      pb        <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr <= clr + TW'(1);
          if (int'(clr) == TDEPTH - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd  <= command;
            pos  <= pos_in;
            xq   <= x_in;
            bs   <= block_size;
            w    <= MWB'(look_in >> BIT_W);
            pw   <= MWB'(look_in >> BIT_W);
            bitn <= look_in[BIT_W-1:0];
            if (command || pos_in < PW'(LINE_LEN)) state <= S_CHK;
          end
        end
        S_CHK, S_PWALK: begin
          if (state == S_CHK) wbuf <= map_rd;
          if (state == S_CHK && !cmd && map_rd[bitn]) begin
            state <= S_IDLE;  // already an obstacle
          end else if (prv_hit) begin
            prev <= prv_val;
            if (cmd) begin
              lo    <= HW'(LINE_LEN);
              hi    <= HW'(prv_val) + HW'(LINE_LEN) + HW'(1);
              best  <= '0;
              pa    <= 1'b0;
              pb    <= 1'b0;
              state <= S_TMAX;
            end else begin
              state <= S_NSTART;
            end
          end else begin
            w     <= w - MWB'(1);
            state <= S_PWALK;
          end
        end
        S_NSTART: begin
          if (nb != '0) begin
            nxt   <= (PW'(pw) << BIT_W) | PW'(low_bit(nb));
            state <= S_MWR;
          end else if (int'(pw) + 1 >= MAP_WORDS) begin
            nxt   <= PW'(LINE_LEN);
            state <= S_MWR;
          end else begin
            w     <= pw + MWB'(1);
            state <= S_NWALK;
          end
        end
        S_NWALK: begin
          if (map_rd != '0) begin
            nxt   <= (PW'(w) << BIT_W) | PW'(low_bit(map_rd));
            state <= S_MWR;
          end else if (int'(w) + 1 >= MAP_WORDS) begin
            nxt   <= PW'(LINE_LEN);
            state <= S_MWR;
          end else begin
            w <= w + MWB'(1);
          end
        end
        S_MWR: begin
          if (nxt > PW'(LINE_LEN)) nxt <= PW'(LINE_LEN);
          node   <= TW'(pos) + TW'(LINE_LEN);
          cur    <= DW'(pos - prev);
          second <= 1'b0;
          state  <= S_TLEAF;
        end
        S_TLEAF: state <= S_TUP;
        S_TUP: begin
          if (parent == TW'(1)) begin
            if (!second && nxt < PW'(LINE_LEN)) begin
              node   <= TW'(nxt) + TW'(LINE_LEN);
              cur    <= DW'(nxt - pos);
              second <= 1'b1;
              state  <= S_TLEAF;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            node <= parent;
            cur  <= up_max;
          end
        end
        S_TMAX: begin
          best <= fold_b;
          if (lo < hi) begin
            pa <= lo[0];
            pb <= hi[0];
            lo <= (lo + HW'(lo[0])) >> 1;
            hi <= (hi - HW'(hi[0])) >> 1;
          end else begin
            pa    <= 1'b0;
            pb    <= 1'b0;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            fits      <= (PW'(fin_max) >= PW'(bs));
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
